// ===== sv/radar_uart_frame_receiver_macros.svh =====
// assertion macros shared by the frame receiver rtl
// expects clk and rst_n in the scope of use
`ifndef RADAR_UART_FRAME_RECEIVER_MACROS_SVH
`define RADAR_UART_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication, checked out of reset
`define RUF_ASSERT_IMPLIES(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RUF_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== sv/ruf_pkg.sv =====
// types, constants and crc step for the framed serial receiver
// no dependencies
package ruf_pkg;

    localparam logic [7:0]  SYNC_BYTE       = 8'h55;
    localparam logic [7:0]  VERSION_HIGH    = 8'h00;
    localparam logic [7:0]  VERSION_LOW     = 8'h01;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [15:0] DEFAULT_MAX_LEN = 16'd4096;

    typedef enum logic [2:0] {
        KIND_PAYLOAD  = 3'd0,
        KIND_GOOD     = 3'd1,
        KIND_HDR_FAIL = 3'd2,
        KIND_TOO_LONG = 3'd3,
        KIND_CRC_FAIL = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_VER_H   = 4'd1,
        PH_VER_L   = 4'd2,
        PH_SEQ     = 4'd3,
        PH_OPC     = 4'd4,
        PH_LEN_H   = 4'd5,
        PH_LEN_L   = 4'd6,
        PH_HCHECK  = 4'd7,
        PH_PAYLOAD = 4'd8,
        PH_CRC_L   = 4'd9,
        PH_CRC_H   = 4'd10
    } phase_t;

    // crc16-modbus over one byte, reflected
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== sv/radar_uart_frame_receiver.sv =====
// Framed serial receiver: sync hunt, header check, payload pass-through, crc16-modbus trailer.
// One byte per clock sustained while no result is held by a stalled consumer; a byte is captured
// in the input register and is decoded from there into the output register when the output can take it.
// The input stalls only while a result is held in the output register by a stalled consumer.
// Payload bytes are delivered before the crc is known; a closing crc-fail status voids them.
// Depends on ruf_pkg and radar_uart_frame_receiver_macros.svh.
`include "radar_uart_frame_receiver_macros.svh"

module radar_uart_frame_receiver
    import ruf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [7:0]  data_byte,
    output logic [7:0]  frame_seq,
    output logic [7:0]  frame_opcode,
    output logic [15:0] frame_length,
    output logic [15:0] message_id,
    output logic        message_id_valid,
    output logic        frame_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic        advance;

    logic [15:0] max_len_reg;

    phase_t      phase_reg, phase_next;
    logic [7:0]  header_sum_reg, header_sum_next;
    logic [7:0]  seq_reg, seq_next;
    logic [7:0]  opcode_reg, opcode_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  rcv_crc_lo_reg, rcv_crc_lo_next;
    logic [15:0] id_reg, id_next;

    logic        res_valid;
    kind_t       res_kind;
    logic [7:0]  res_data;
    logic [15:0] res_id;
    logic        res_id_valid;

    logic        out_valid_reg, out_valid_next;
    kind_t       kind_reg;
    logic [7:0]  data_reg;
    logic [7:0]  seq_out_reg;
    logic [7:0]  opcode_out_reg;
    logic [15:0] length_out_reg;
    logic [15:0] id_out_reg;
    logic        id_valid_out_reg;
    logic        last_out_reg;

    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (in_valid && !in_stall)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            s1_byte_reg <= rx_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= DEFAULT_MAX_LEN;
        else if (cfg_valid && cfg_ready)
            max_len_reg <= cfg_data;
    end

    // frame decode
    always_comb
    begin
        logic [7:0]  b;
        logic [7:0]  expected;
        logic [15:0] count_inc;
        b         = s1_byte_reg;
        expected  = ~(header_sum_reg - 8'd1);
        count_inc = count_reg + 16'd1;

        phase_next      = phase_reg;
        header_sum_next = header_sum_reg;
        seq_next        = seq_reg;
        opcode_next     = opcode_reg;
        length_next     = length_reg;
        count_next      = count_reg;
        crc_next        = crc_reg;
        rcv_crc_lo_next = rcv_crc_lo_reg;
        id_next         = id_reg;

        res_valid    = 1'b0;
        res_kind     = KIND_PAYLOAD;
        res_data     = 8'h00;
        res_id       = 16'h0000;
        res_id_valid = 1'b0;

        if (phase_reg >= PH_VER_H && phase_reg < PH_HCHECK)
            header_sum_next = header_sum_reg + b;
        if (phase_reg >= PH_VER_H && phase_reg <= PH_PAYLOAD)
            crc_next = crc_byte(crc_reg, b);

        unique case (phase_reg)
            PH_HUNT:
            begin
                if (b == SYNC_BYTE)
                begin
                    phase_next      = PH_VER_H;
                    header_sum_next = b;
                    crc_next        = crc_byte(CRC_INIT, b);
                    count_next      = 16'h0000;
                    id_next         = 16'h0000;
                end
            end
            PH_VER_H:
                phase_next = (b == VERSION_HIGH) ? PH_VER_L : PH_HUNT;
            PH_VER_L:
                phase_next = (b == VERSION_LOW) ? PH_SEQ : PH_HUNT;
            PH_SEQ:
            begin
                seq_next   = b;
                phase_next = PH_OPC;
            end
            PH_OPC:
            begin
                opcode_next = b;
                phase_next  = PH_LEN_H;
            end
            PH_LEN_H:
            begin
                length_next = {b, 8'h00};
                phase_next  = PH_LEN_L;
            end
            PH_LEN_L:
            begin
                length_next = {length_reg[15:8], b};
                phase_next  = PH_HCHECK;
            end
            PH_HCHECK:
            begin
                if (b != expected)
                begin
                    phase_next = PH_HUNT;
                    res_valid  = 1'b1;
                    res_kind   = KIND_HDR_FAIL;
                end
                else if (length_reg > max_len_reg)
                begin
                    phase_next = PH_HUNT;
                    res_valid  = 1'b1;
                    res_kind   = KIND_TOO_LONG;
                end
                else
                    phase_next = (length_reg == 16'h0000) ? PH_CRC_L : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                if (count_reg == 16'd0)
                    id_next = {b, 8'h00};
                else if (count_reg == 16'd1)
                    id_next = {id_reg[15:8], b};
                count_next = count_inc;
                if (count_inc == length_reg)
                    phase_next = PH_CRC_L;
                res_valid = 1'b1;
                res_kind  = KIND_PAYLOAD;
                res_data  = b;
            end
            PH_CRC_L:
            begin
                rcv_crc_lo_next = b;
                phase_next      = PH_CRC_H;
            end
            PH_CRC_H:
            begin
                phase_next = PH_HUNT;
                res_valid  = 1'b1;
                if ({b, rcv_crc_lo_reg} == crc_reg)
                begin
                    res_kind = KIND_GOOD;
                    if (length_reg >= 16'd2)
                    begin
                        res_id       = id_reg;
                        res_id_valid = 1'b1;
                    end
                end
                else
                    res_kind = KIND_CRC_FAIL;
            end
            default:
                phase_next = PH_HUNT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            header_sum_reg <= 8'h00;
            seq_reg        <= 8'h00;
            opcode_reg     <= 8'h00;
            length_reg     <= 16'h0000;
            count_reg      <= 16'h0000;
            crc_reg        <= CRC_INIT;
            rcv_crc_lo_reg <= 8'h00;
            id_reg         <= 16'h0000;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            header_sum_reg <= header_sum_next;
            seq_reg        <= seq_next;
            opcode_reg     <= opcode_next;
            length_reg     <= length_next;
            count_reg      <= count_next;
            crc_reg        <= crc_next;
            rcv_crc_lo_reg <= rcv_crc_lo_next;
            id_reg         <= id_next;
        end
    end

    // output word register
    always_comb
    begin
        if (advance)
            out_valid_next = res_valid;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            kind_reg         <= res_kind;
            data_reg         <= res_data;
            seq_out_reg      <= seq_reg;
            opcode_out_reg   <= opcode_reg;
            length_out_reg   <= length_reg;
            id_out_reg       <= res_id;
            id_valid_out_reg <= res_id_valid;
            last_out_reg     <= (res_kind != KIND_PAYLOAD);
        end
    end

    assign out_valid        = out_valid_reg;
    assign kind             = kind_reg;
    assign data_byte        = data_reg;
    assign frame_seq        = seq_out_reg;
    assign frame_opcode     = opcode_out_reg;
    assign frame_length     = length_out_reg;
    assign message_id       = id_out_reg;
    assign message_id_valid = id_valid_out_reg;
    assign frame_last       = last_out_reg;

    `RUF_ASSERT_IMPLIES(a_last_matches_kind, out_valid_reg,
        (last_out_reg == (kind_reg != KIND_PAYLOAD)), "frame_last disagrees with kind")
    `RUF_ASSERT_IMPLIES(a_id_only_on_good, out_valid_reg && id_valid_out_reg,
        (kind_reg == KIND_GOOD && length_out_reg >= 16'd2), "message id on a bad status")
    `RUF_ASSERT_IMPLIES(a_payload_in_range, phase_reg == PH_PAYLOAD,
        (length_reg != 16'h0000 && count_reg < length_reg), "payload count past length")
    `RUF_ASSERT_NEXT(a_stall_holds_phase, in_stall,
        $stable(phase_reg) && $stable(crc_reg), "frame state moved while stalled")

endmodule
